// File: sv/hierarchical_next_hop_router_top_assert.svh
// Assertion macros used by the router sequencer.
`ifndef HIERARCHICAL_NEXT_HOP_ROUTER_TOP_ASSERT_SVH
`define HIERARCHICAL_NEXT_HOP_ROUTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HNH_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hnh assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HNH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hnh assertion failed");

`endif

// File: sv/hnh_pkg.sv
// Package with widths, constants, state and result types of the router.
`timescale 1ns / 1ps

package hnh_pkg;

    localparam int ADDR_W         = 8;
    localparam int IFACE_W        = 3;
    localparam int SUBNET_SIZE    = 'h20;
    localparam int BRANCH_UNIT    = 'h10;
    localparam int SUBNET_BITS    = $clog2(SUBNET_SIZE);
    localparam int BRANCH_BITS    = $clog2(BRANCH_UNIT);
    localparam int WALK_STEPS     = 3;
    localparam int WALK_CNT_W     = $clog2(WALK_STEPS + 1);
    localparam int NUM_IFACES_DEF = 8;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [IFACE_W-1:0] iface_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_WALK,
        ST_DONE
    } hnh_state_t;

    typedef struct packed {
        addr_t  relay;
        iface_t iface;
    } hnh_res_t;

endpackage

// File: sv/hierarchical_next_hop_router_top.sv
// A request passes the sequencer states EVAL and DONE, then the output register, on its
// way to m_valid; a route that walks the parent chain also passes WALK between EVAL and
// DONE, one relay-unit step per cycle for up to 4 checks. s_ready is low outside idle.
// The output register holds a result while the sequencer returns to idle.
// Reset (aresetn low, synchronous) clears own_address to 0 and drops all requests.
// Top level of the hierarchical next-hop router.
`timescale 1ns / 1ps

module hierarchical_next_hop_router_top #(
    parameter int NUM_IFACES = hnh_pkg::NUM_IFACES_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [7:0]              cfg_own_address,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              s_dest_address,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [7:0]              m_relay,
    output logic [2:0]              m_interface_index
);

    hnh_pkg::addr_t     own_reg;
    hnh_pkg::addr_t     unit_addr, unit_relay;
    hnh_pkg::hnh_res_t  res, m_res_reg;
    logic               res_valid, out_free, m_valid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_reg <= '0;
        end else if (cfg_valid) begin
            own_reg <= cfg_own_address;
        end
    end

    hnh_relay_unit u_relay (
        .addr  (unit_addr),
        .relay (unit_relay)
    );

    hnh_seq #(
        .NUM_IFACES (NUM_IFACES)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .own_addr       (own_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_dest_address (s_dest_address),
        .unit_addr      (unit_addr),
        .unit_relay     (unit_relay),
        .res_valid      (res_valid),
        .res            (res),
        .out_free       (out_free)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_relay           = m_res_reg.relay;
    assign m_interface_index = m_res_reg.iface;

endmodule

// File: sv/hnh_relay_unit.sv
// Shared unit that derives the parent (cell relay) address of one address.
`timescale 1ns / 1ps

module hnh_relay_unit (
    input  hnh_pkg::addr_t addr,
    output hnh_pkg::addr_t relay
);

    localparam int HI_W = hnh_pkg::ADDR_W - hnh_pkg::SUBNET_BITS;

    logic [HI_W-1:0]                 subnet_no;
    logic [hnh_pkg::SUBNET_BITS-1:0] member_no;

    assign subnet_no = addr[hnh_pkg::ADDR_W-1:hnh_pkg::SUBNET_BITS];
    assign member_no = addr[hnh_pkg::SUBNET_BITS-1:0];

    always_comb begin
        priority if (addr < hnh_pkg::addr_t'(2)) begin
            relay = '0;
        end else if (subnet_no == '0) begin
            relay = hnh_pkg::addr_t'(1);
        end else if (member_no != '0) begin
            // A leaf hangs off the hub at the bottom of its subnet.
            relay = {subnet_no, {hnh_pkg::SUBNET_BITS{1'b0}}};
        end else begin
            // A hub hangs off base station a/16.
            relay = addr >> hnh_pkg::BRANCH_BITS;
        end
    end

endmodule

// File: sv/hnh_seq.sv
// Sequencer that applies the routing rules and walks the parent chain.
`timescale 1ns / 1ps

`include "hierarchical_next_hop_router_top_assert.svh"

module hnh_seq #(
    parameter int NUM_IFACES = hnh_pkg::NUM_IFACES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  hnh_pkg::addr_t     own_addr,
    input  logic               s_valid,
    output logic               s_ready,
    input  hnh_pkg::addr_t     s_dest_address,
    output hnh_pkg::addr_t     unit_addr,
    input  hnh_pkg::addr_t     unit_relay,
    output logic               res_valid,
    output hnh_pkg::hnh_res_t  res,
    input  logic               out_free
);

    localparam int LUT_N = 1 << (hnh_pkg::SUBNET_BITS - 1);

    hnh_pkg::hnh_state_t                  state_reg, state_next;
    hnh_pkg::addr_t                       hop_reg, hop_next;
    logic [hnh_pkg::WALK_CNT_W-1:0]       cnt_reg, cnt_next;
    hnh_pkg::hnh_res_t                    res_reg, res_next;
    hnh_pkg::iface_t                      iface_lut [LUT_N];
    hnh_pkg::addr_t                       br_own, br_dest;
    logic [2:0]                           dp_own, dp_dest;

    function automatic hnh_pkg::addr_t branch_of(input hnh_pkg::addr_t a);
        hnh_pkg::addr_t b;
        priority if (a < hnh_pkg::addr_t'(2)) begin
            b = '0;
        end else if ((a >> hnh_pkg::SUBNET_BITS) == '0) begin
            b = a;
        end else begin
            b = (a >> hnh_pkg::SUBNET_BITS) << 1;
        end
        return b;
    endfunction

    function automatic logic [2:0] depth_of(input hnh_pkg::addr_t a);
        logic [2:0] d;
        priority if (a == '0) begin
            d = 3'd0;
        end else if (a == hnh_pkg::addr_t'(1)) begin
            d = 3'd1;
        end else if ((a >> hnh_pkg::SUBNET_BITS) == '0) begin
            d = 3'd2;
        end else if (a[hnh_pkg::SUBNET_BITS-1:0] == '0) begin
            d = 3'd3;
        end else begin
            d = 3'd4;
        end
        return d;
    endfunction

    // Interface of the host toward each pair of branches.
    for (genvar g = 0; g < LUT_N; g++) begin : g_lut
        assign iface_lut[g] = hnh_pkg::iface_t'(g % NUM_IFACES);
    end

    assign br_own  = branch_of(own_addr);
    assign br_dest = branch_of(hop_reg);
    assign dp_own  = depth_of(own_addr);
    assign dp_dest = depth_of(hop_reg);

    assign s_ready   = (state_reg == hnh_pkg::ST_IDLE);
    assign res_valid = (state_reg == hnh_pkg::ST_DONE);
    assign res       = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hnh_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        hop_reg <= hop_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

    always_comb begin
        state_next = state_reg;
        hop_next   = hop_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        // The shared unit sees our own address except while walking.
        unit_addr  = (state_reg == hnh_pkg::ST_WALK) ? hop_reg : own_addr;
        unique case (state_reg)
            hnh_pkg::ST_IDLE: begin
                if (s_valid) begin
                    hop_next   = s_dest_address;
                    cnt_next   = '0;
                    state_next = hnh_pkg::ST_EVAL;
                end
            end
            hnh_pkg::ST_EVAL: begin
                res_next.iface = '0;
                res_next.relay = unit_relay;
                state_next     = hnh_pkg::ST_DONE;
                priority if (own_addr == '0) begin
                    res_next.relay = hnh_pkg::addr_t'(1);
                end else if (hop_reg < hnh_pkg::addr_t'(2)) begin
                    res_next.relay = unit_relay;
                end else if (own_addr == hnh_pkg::addr_t'(1)) begin
                    res_next.relay = br_dest;
                    res_next.iface = iface_lut[br_dest[hnh_pkg::SUBNET_BITS-1:1]];
                end else if (br_own == br_dest) begin
                    priority if (dp_dest > dp_own) begin
                        res_next.iface = (dp_own == 3'd2) ? hnh_pkg::iface_t'(1) : '0;
                        state_next     = hnh_pkg::ST_WALK;
                    end else if (dp_dest == dp_own) begin
                        res_next.relay = hop_reg;
                    end else begin
                        res_next.relay = unit_relay;
                    end
                end else begin
                    res_next.relay = unit_relay;
                end
            end
            hnh_pkg::ST_WALK: begin
                if (unit_relay == own_addr ||
                        cnt_reg == hnh_pkg::WALK_CNT_W'(hnh_pkg::WALK_STEPS)) begin
                    res_next.relay = hop_reg;
                    state_next     = hnh_pkg::ST_DONE;
                end else begin
                    hop_next = unit_relay;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            hnh_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = hnh_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hnh_pkg::ST_IDLE;
            end
        endcase
    end

    `HNH_ASSERT_NEXT(a_accept_loads, aclk, aresetn, s_valid && s_ready,
        state_reg == hnh_pkg::ST_EVAL && hop_reg == $past(s_dest_address))
    `HNH_ASSERT_NEXT(a_walk_meets_own, aclk, aresetn,
        state_reg == hnh_pkg::ST_WALK && unit_relay == own_addr,
        state_reg == hnh_pkg::ST_DONE && res_reg.relay == $past(hop_reg))
    `HNH_ASSERT_NEXT(a_result_waits, aclk, aresetn,
        state_reg == hnh_pkg::ST_DONE && !out_free,
        state_reg == hnh_pkg::ST_DONE && $stable(res_reg))

endmodule

// File: dv/next_hop_checker.sv
// Checker that predicts each route from the observed own address and compares results.
`timescale 1ns / 1ps

module next_hop_checker #(
    parameter int NUM_IFACES = hnh_pkg::NUM_IFACES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [7:0] cfg_own_address,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_dest_address,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_relay,
    input  logic [2:0] m_interface_index,
    output int         pending_routes,
    output int         mismatch_count
);

    hnh_pkg::hnh_res_t expected_routes[$];
    hnh_pkg::addr_t    own_address_q = '0;
    int                errs = 0;

    function automatic hnh_pkg::addr_t parent_of(input hnh_pkg::addr_t a);
        if (a < 2)
            return '0;
        if (a < hnh_pkg::SUBNET_SIZE)
            return hnh_pkg::addr_t'(1);
        if ((a & hnh_pkg::addr_t'(hnh_pkg::SUBNET_SIZE - 1)) != '0)
            return a & ~hnh_pkg::addr_t'(hnh_pkg::SUBNET_SIZE - 1);
        // A hub hangs off the base station numbered a/16.
        return hnh_pkg::addr_t'(a >> hnh_pkg::BRANCH_BITS);
    endfunction

    function automatic int tree_depth(input hnh_pkg::addr_t a);
        if (a == 0)
            return 0;
        if (a == 1)
            return 1;
        if (parent_of(a) == 1)
            return 2;
        if (parent_of(a) < hnh_pkg::SUBNET_SIZE)
            return 3;
        return 4;
    endfunction

    function automatic hnh_pkg::addr_t branch_of_addr(input hnh_pkg::addr_t a);
        if (a < 2)
            return '0;
        if (a < hnh_pkg::SUBNET_SIZE)
            return a;
        return hnh_pkg::addr_t'((a >> hnh_pkg::SUBNET_BITS) << 1);
    endfunction

    function automatic hnh_pkg::hnh_res_t predict_route(input hnh_pkg::addr_t own,
                                                        input hnh_pkg::addr_t dest);
        hnh_pkg::hnh_res_t r;
        hnh_pkg::addr_t    hop;
        hnh_pkg::addr_t    up;
        int                b;
        int                du;
        int                dd;
        r.relay = parent_of(own);
        r.iface = '0;
        if (own == 0) begin
            r.relay = hnh_pkg::addr_t'(1);
        end else if (dest >= 2) begin
            if (own == 1) begin
                b = int'(branch_of_addr(dest));
                r.relay = hnh_pkg::addr_t'(b);
                r.iface = hnh_pkg::iface_t'(((b * hnh_pkg::BRANCH_UNIT) /
                                             hnh_pkg::SUBNET_SIZE) % NUM_IFACES);
            end else if (branch_of_addr(own) == branch_of_addr(dest)) begin
                du = tree_depth(own);
                dd = tree_depth(dest);
                if (dd > du) begin
                    // Climb from the destination until the parent is this node.
                    hop = dest;
                    up  = parent_of(hop);
                    for (int i = 0; i < hnh_pkg::WALK_STEPS && up != own; i++) begin
                        hop = up;
                        up  = parent_of(hop);
                    end
                    r.relay = hop;
                    if (du == 2)
                        r.iface = hnh_pkg::iface_t'(1);
                end else if (dd == du) begin
                    r.relay = dest;
                end
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        hnh_pkg::hnh_res_t want;
        if (!aresetn) begin
            own_address_q = '0;
            expected_routes.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                own_address_q = cfg_own_address;
            if (m_valid && m_ready) begin
                if (expected_routes.size() == 0) begin
                    $display("%0t: unexpected route relay %0d iface %0d", $time,
                             m_relay, m_interface_index);
                    errs++;
                end else begin
                    want = expected_routes.pop_front();
                    if (m_relay !== want.relay) begin
                        $display("%0t: relay expected %0d actual %0d", $time,
                                 want.relay, m_relay);
                        errs++;
                    end
                    if (m_interface_index !== want.iface) begin
                        $display("%0t: interface_index expected %0d actual %0d", $time,
                                 want.iface, m_interface_index);
                        errs++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_routes.push_back(predict_route(own_address_q, s_dest_address));
        end
        pending_routes <= expected_routes.size();
        mismatch_count <= errs;
    end

endmodule

// File: dv/testbench.sv
// Top of the router testbench: clock, reset, stimulus, stalls and the verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 80;
    localparam int DIRECTED_N    = 23;

    logic       aclk;
    logic       aresetn         = 1'b0;
    logic       cfg_valid       = 1'b0;
    logic [7:0] cfg_own_address = '0;
    logic       s_valid         = 1'b0;
    logic [7:0] s_dest_address  = '0;
    logic       m_ready         = 1'b0;
    logic       cfg_ready;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_relay;
    logic [2:0] m_interface_index;

    int pending_routes;
    int mismatch_count;
    int stall_left  = 0;
    int idle_cycles = 0;
    bit quiet       = 1'b0;

    // Host, base station, hub, leaf and top-address cases.
    hnh_pkg::addr_t dir_own [DIRECTED_N] = '{
        8'd0, 8'd0,
        8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
        8'd4, 8'd4, 8'd4, 8'd4, 8'd4,
        8'd64, 8'd64, 8'd64, 8'd64,
        8'd65, 8'd65, 8'd65,
        8'd255, 8'd255, 8'd255
    };
    hnh_pkg::addr_t dir_dest [DIRECTED_N] = '{
        8'd0, 8'd255,
        8'd0, 8'd1, 8'd2, 8'd31, 8'd32, 8'd255,
        8'd1, 8'd64, 8'd65, 8'd4, 8'd3,
        8'd0, 8'd95, 8'd4, 8'd96,
        8'd66, 8'd64, 8'd65,
        8'd224, 8'd254, 8'd1
    };

    hierarchical_next_hop_router_top dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_own_address   (cfg_own_address),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_dest_address    (s_dest_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_relay           (m_relay),
        .m_interface_index (m_interface_index)
    );

    next_hop_checker checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_own_address   (cfg_own_address),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_dest_address    (s_dest_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_relay           (m_relay),
        .m_interface_index (m_interface_index),
        .pending_routes    (pending_routes),
        .mismatch_count    (mismatch_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side stalls m_ready in random bursts.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 5);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (cfg_valid && cfg_ready) || (s_valid && s_ready) ||
            (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // The register may change only once every outstanding request has drained.
    task automatic write_own_address(input hnh_pkg::addr_t value);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_routes != 0);
        cfg_valid       <= 1'b1;
        cfg_own_address <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_route(input hnh_pkg::addr_t dest);
        int gap;
        s_valid        <= 1'b1;
        s_dest_address <= dest;
        do @(posedge aclk); while (!s_ready);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic hnh_pkg::addr_t pick_own(input int phase);
        hnh_pkg::addr_t a;
        case (phase)
            0:       a = 8'd255;
            1:       a = 8'd0;
            2:       a = 8'd1;
            default: begin
                case ($urandom_range(0, 4))
                    0:       a = hnh_pkg::addr_t'($urandom_range(2, 31));
                    1:       a = {3'($urandom_range(1, 7)), 5'b0};
                    2:       a = {3'($urandom_range(1, 7)), 5'($urandom_range(1, 31))};
                    3:       a = hnh_pkg::addr_t'($urandom);
                    default: a = 8'd1;
                endcase
            end
        endcase
        return a;
    endfunction

    // A mix of random destinations and ones in this node's subnet, so the same-branch rules get hit.
    function automatic hnh_pkg::addr_t pick_dest(input hnh_pkg::addr_t own);
        hnh_pkg::addr_t d;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: d = hnh_pkg::addr_t'($urandom);
            4, 5:       d = {own[7:5], 5'($urandom)};
            6:          d = {own[3:1], 5'($urandom)};
            7:          d = {3'($urandom), 5'b0};
            8:          d = hnh_pkg::addr_t'($urandom_range(2, 31));
            default:    d = hnh_pkg::addr_t'($urandom_range(0, 1));
        endcase
        return d;
    endfunction

    initial begin
        hnh_pkg::addr_t own;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < DIRECTED_N; i++) begin
            if (i == 0 || dir_own[i] != dir_own[i - 1])
                write_own_address(dir_own[i]);
            send_route(dir_dest[i]);
        end
        for (int k = 0; k < RANDOM_PHASES; k++) begin
            own = pick_own(k);
            write_own_address(own);
            quiet <= (k == RANDOM_PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_route(pick_dest(own));
        end
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_routes != 0);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
